[sv/swept_aabb_pair_response_macros.svh]
// Assertion macros for the swept box pair response RTL (used by sapr_queue).
// Needs clk and arst_n in the scope of each use.
`ifndef SWEPT_AABB_PAIR_RESPONSE_MACROS_SVH
`define SWEPT_AABB_PAIR_RESPONSE_MACROS_SVH
`ifndef ASSERT_OFF
`define SAPR_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);
`define SAPR_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SAPR_ASSERT(lbl, expr, msg)
`define SAPR_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

[sv/sapr_pkg.sv]
// Types and constants for the swept box pair response block.
// No dependencies.
package sapr_pkg;
	localparam logic [1:0] TYPE_MM  = 2'd0;
	localparam logic [1:0] TYPE_MF  = 2'd1;
	localparam logic [1:0] TYPE_MA  = 2'd2;
	localparam logic [1:0] TYPE_RSV = 2'd3;

	localparam logic [3:0] SIDE_RIGHT = 4'b0001;
	localparam logic [3:0] SIDE_LEFT  = 4'b0010;
	localparam logic [3:0] SIDE_DOWN  = 4'b0100;
	localparam logic [3:0] SIDE_UP    = 4'b1000;

	localparam logic signed [31:0] T_MAX = 32'sh7FFF_FFFF;

	localparam int QDEPTH = 4;
	localparam int QAW    = 2;

	typedef struct packed {
		logic [1:0]  req_type;
		logic        hit;
		logic [31:0] avx;
		logic [31:0] avy;
		logic [31:0] bvx;
		logic [31:0] bvy;
		logic [63:0] layers;
	} ctx_t;

	typedef struct packed {
		ctx_t        ctx;
		logic [31:0] gx_mag;
		logic        gx_neg;
		logic [32:0] spx;
		logic [31:0] gy_mag;
		logic        gy_neg;
		logic [32:0] spy;
	} front_t;
endpackage

[sv/sapr_front.sv]
// Front end: accepts a box pair, tests the swept overlap, forms gaps and speeds.
// Depends on sapr_pkg.
module sapr_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_valid,
	output logic            s_ready,
	input  logic [447:0]    s_data,
	input  logic [1:0]      s_user,
	output logic            q_valid,
	input  logic            q_ready,
	output sapr_pkg::front_t q_item
);
	import sapr_pkg::*;

	logic signed [31:0] a0x, a0y, a1x, a1y, avx, avy;
	logic signed [31:0] b0x, b0y, b1x, b1y, bvx, bvy;
	logic signed [32:0] sbx, sby;
	logic               mm, hit;
	logic signed [31:0] mxx, mnx, mxy, mny;
	logic signed [32:0] gx, gy, gxa, gya;
	logic signed [32:0] aax, aay, abx, aby;
	logic [32:0]        spx, spy;
	logic               v_s1;
	front_t             item_s1;

	assign a0x = s_data[31:0];
	assign a0y = s_data[63:32];
	assign a1x = s_data[95:64];
	assign a1y = s_data[127:96];
	assign avx = s_data[159:128];
	assign avy = s_data[191:160];
	assign b0x = s_data[223:192];
	assign b0y = s_data[255:224];
	assign b1x = s_data[287:256];
	assign b1y = s_data[319:288];
	assign bvx = s_data[351:320];
	assign bvy = s_data[383:352];

	always_comb begin
		mm  = (s_user == TYPE_MM);
		sbx = mm ? 33'(bvx) : 33'sd0;
		sby = mm ? 33'(bvy) : 33'sd0;
		hit = (s_user != TYPE_RSV)
			&& (33'(a1x) + 33'(avx) > 33'(b0x) + sbx)
			&& (33'(a0x) + 33'(avx) < 33'(b1x) + sbx)
			&& (33'(a1y) + 33'(avy) > 33'(b0y) + sby)
			&& (33'(a0y) + 33'(avy) < 33'(b1y) + sby);
		mxx = (a0x > b0x) ? a0x : b0x;
		mnx = (a1x < b1x) ? a1x : b1x;
		mxy = (a0y > b0y) ? a0y : b0y;
		mny = (a1y < b1y) ? a1y : b1y;
		gx  = 33'(mxx) - 33'(mnx);
		gy  = 33'(mxy) - 33'(mny);
		gxa = gx[32] ? -gx : gx;
		gya = gy[32] ? -gy : gy;
		aax = avx[31] ? -33'(avx) : 33'(avx);
		aay = avy[31] ? -33'(avy) : 33'(avy);
		abx = bvx[31] ? -33'(bvx) : 33'(bvx);
		aby = bvy[31] ? -33'(bvy) : 33'(bvy);
		spx = {1'b0, aax[31:0]} + (mm ? {1'b0, abx[31:0]} : 33'd0);
		spy = {1'b0, aay[31:0]} + (mm ? {1'b0, aby[31:0]} : 33'd0);
	end

	assign s_ready = !v_s1 || q_ready;
	assign q_valid = v_s1;
	assign q_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_ready) begin
			v_s1 <= s_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_ready && s_valid) begin
			item_s1.ctx.req_type <= s_user;
			item_s1.ctx.hit      <= hit;
			item_s1.ctx.avx      <= avx;
			item_s1.ctx.avy      <= avy;
			item_s1.ctx.bvx      <= bvx;
			item_s1.ctx.bvy      <= bvy;
			item_s1.ctx.layers   <= s_data[447:384];
			item_s1.gx_mag       <= gxa[31:0];
			item_s1.gx_neg       <= gx[32];
			item_s1.spx          <= spx;
			item_s1.gy_mag       <= gya[31:0];
			item_s1.gy_neg       <= gy[32];
			item_s1.spy          <= spy;
		end
	end
endmodule

[sv/sapr_queue.sv]
// Short queue between the front end and the divide/scale back end.
// Depends on sapr_pkg and the assertion macros.
`include "swept_aabb_pair_response_macros.svh"
module sapr_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  sapr_pkg::front_t push_item,
	output logic             pop_valid,
	input  logic             pop,
	output sapr_pkg::front_t pop_item
);
	import sapr_pkg::*;

	front_t         buf_q [QDEPTH];
	logic [QAW-1:0] wp_q, rp_q;
	logic [QAW:0]   count_q;
	logic           push;

	assign push_ready = (count_q != (QAW+1)'(QDEPTH));
	assign push       = push_valid && push_ready;
	assign pop_valid  = (count_q != '0);
	assign pop_item   = buf_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop)  rp_q <= rp_q + 1'b1;
			count_q <= count_q + (QAW+1)'(push) - (QAW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) buf_q[wp_q] <= push_item;
	end

	`SAPR_ASSERT(a_count_bound, count_q <= (QAW+1)'(QDEPTH), "queue count above depth")
	`SAPR_ASSERT(a_pop_nonempty, !pop || pop_valid, "pop from empty queue")
	`SAPR_ASSERT_IMP(a_count_up, push && !pop, count_q == $past(count_q) + 1'b1, "count lost a push")
endmodule

[sv/sapr_back.sv]
// Back end: pipelined restoring division per axis, axis choice, velocity scaling.
// Depends on sapr_pkg.
module sapr_back #(
	parameter int FB = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	output logic             q_pop,
	input  sapr_pkg::front_t q_item,
	output logic             m_valid,
	input  logic             m_ready,
	output logic [199:0]     m_data,
	output logic             m_hit
);
	import sapr_pkg::*;

	localparam int NW = 32 + FB;
	localparam int DS = 32;

	logic          en;
	logic          v_s  [DS+1];
	ctx_t          ctx_s[DS+1];
	logic [NW-1:0] rx_s [DS+1];
	logic [NW-1:0] ry_s [DS+1];
	logic [32:0]   dx_s [DS+1];
	logic [32:0]   dy_s [DS+1];
	logic [31:0]   qx_s [DS+1];
	logic [31:0]   qy_s [DS+1];
	logic          nx_s [DS+1];
	logic          ny_s [DS+1];

	assign en    = !m_valid || m_ready;
	assign q_pop = en && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= q_pop;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			ctx_s[0] <= q_item.ctx;
			rx_s[0]  <= {q_item.gx_mag, FB'(0)};
			ry_s[0]  <= {q_item.gy_mag, FB'(0)};
			dx_s[0]  <= q_item.spx;
			dy_s[0]  <= q_item.spy;
			qx_s[0]  <= '0;
			qy_s[0]  <= '0;
			nx_s[0]  <= q_item.gx_neg;
			ny_s[0]  <= q_item.gy_neg;
		end
	end

	for (genvar i = 0; i < DS; i++) begin : g_div
		localparam int B = DS - 1 - i;
		logic [64:0]   shx, shy, rxe, rye, dfx, dfy;
		logic          gex, gey;
		logic [31:0]   nqx, nqy;
		logic [NW-1:0] nrx, nry;

		always_comb begin
			shx = {32'd0, dx_s[i]} << B;
			shy = {32'd0, dy_s[i]} << B;
			rxe = 65'(rx_s[i]);
			rye = 65'(ry_s[i]);
			gex = (rxe >= shx);
			gey = (rye >= shy);
			dfx = rxe - shx;
			dfy = rye - shy;
			nrx = gex ? dfx[NW-1:0] : rx_s[i];
			nry = gey ? dfy[NW-1:0] : ry_s[i];
			nqx = qx_s[i];
			nqy = qy_s[i];
			nqx[B] = gex;
			nqy[B] = gey;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en && v_s[i]) begin
				ctx_s[i+1] <= ctx_s[i];
				rx_s[i+1]  <= nrx;
				ry_s[i+1]  <= nry;
				dx_s[i+1]  <= dx_s[i];
				dy_s[i+1]  <= dy_s[i];
				qx_s[i+1]  <= nqx;
				qy_s[i+1]  <= nqy;
				nx_s[i+1]  <= nx_s[i];
				ny_s[i+1]  <= ny_s[i];
			end
		end
	end

	logic               infx, infy, lts, lta;
	logic signed [31:0] satx, saty, tx, ty, k;
	logic [3:0]         fs, ss;
	ctx_t               cx;

	always_comb begin
		cx   = ctx_s[DS];
		infx = (dx_s[DS] == '0);
		infy = (dy_s[DS] == '0);
		satx = qx_s[DS][31] ? T_MAX : $signed({1'b0, qx_s[DS][30:0]});
		saty = qy_s[DS][31] ? T_MAX : $signed({1'b0, qy_s[DS][30:0]});
		tx   = nx_s[DS] ? -satx : satx;
		ty   = ny_s[DS] ? -saty : saty;
		lts  = infx ? 1'b0 : (infy ? 1'b1 : (tx < ty));
		lta  = infx ? 1'b0 : (infy ? 1'b1 : (satx < saty));
		if (lta) k = infx ? 32'sd0 : tx;
		else     k = infy ? 32'sd0 : ty;
		if (lts) begin
			fs = $signed(cx.avx) > 0 ? SIDE_RIGHT : SIDE_LEFT;
			ss = $signed(cx.avx) > 0 ? SIDE_LEFT : SIDE_RIGHT;
		end else begin
			fs = $signed(cx.avy) > 0 ? SIDE_DOWN : SIDE_UP;
			ss = $signed(cx.avy) > 0 ? SIDE_UP : SIDE_DOWN;
		end
	end

	logic               v_p1, v_p2;
	ctx_t               ctx_p1, ctx_p2;
	logic               lta_p1, lta_p2;
	logic [3:0]         fs_p1, ss_p1, fs_p2, ss_p2;
	logic signed [31:0] k_p1, vf_p1, vs_p1;
	logic signed [63:0] pf_p2, ps_p2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_p1    <= 1'b0;
			v_p2    <= 1'b0;
			m_valid <= 1'b0;
		end else if (en) begin
			v_p1    <= v_s[DS];
			v_p2    <= v_p1;
			m_valid <= v_p2;
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_s[DS]) begin
			ctx_p1 <= cx;
			lta_p1 <= lta;
			fs_p1  <= fs;
			ss_p1  <= ss;
			k_p1   <= k;
			vf_p1  <= lta ? cx.avx : cx.avy;
			vs_p1  <= lta ? cx.bvx : cx.bvy;
		end
		if (en && v_p1) begin
			ctx_p2 <= ctx_p1;
			lta_p2 <= lta_p1;
			fs_p2  <= fs_p1;
			ss_p2  <= ss_p1;
			pf_p2  <= vf_p1 * k_p1;
			ps_p2  <= vs_p1 * k_p1;
		end
	end

	logic signed [63:0] shf, shs;
	logic [31:0]        rf, rs;
	logic [63:0]        fv, sv;

	always_comb begin
		shf = pf_p2 >>> FB;
		shs = ps_p2 >>> FB;
		if (shf > 64'sh7FFF_FFFF)        rf = 32'h7FFF_FFFF;
		else if (shf < -64'sh8000_0000)  rf = 32'h8000_0000;
		else                             rf = shf[31:0];
		if (shs > 64'sh7FFF_FFFF)        rs = 32'h7FFF_FFFF;
		else if (shs < -64'sh8000_0000)  rs = 32'h8000_0000;
		else                             rs = shs[31:0];
		fv = {ctx_p2.avy, ctx_p2.avx};
		sv = {ctx_p2.bvy, ctx_p2.bvx};
		if (ctx_p2.hit && ctx_p2.req_type != TYPE_MA) begin
			fv = lta_p2 ? {ctx_p2.avy, rf} : {rf, ctx_p2.avx};
			if (ctx_p2.req_type == TYPE_MM) begin
				sv = lta_p2 ? {ctx_p2.bvy, rs} : {rs, ctx_p2.bvx};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_p2) begin
			m_hit  <= ctx_p2.hit;
			m_data <= {ctx_p2.hit ? ctx_p2.layers : 64'd0,
				ctx_p2.hit ? ss_p2 : 4'd0,
				ctx_p2.hit ? fs_p2 : 4'd0,
				sv, fv};
		end
	end
endmodule

[sv/swept_aabb_pair_response.sv]
// Top level of the swept box pair response block.
// Depends on sapr_pkg, sapr_front, sapr_queue and sapr_back.
//
// Input stream s_*: one box pair per transfer. Output stream m_*: one
// result per pair, in order.
// Pipeline from input transfer to output valid: 1 front register, 1 queue
// write, a divider load register, 32 restoring divide stages, compare,
// multiply and output register stages.
// Throughput: one pair per cycle while m_tready is high; the divide pipeline
// takes one quotient bit per stage for both axes at once.
// Reset clears all valid flags and the queue; payload registers keep
// whatever they hold. When m_tvalid is high and m_tready is low the back
// pipeline holds, the four-entry queue fills and then s_tready drops.
// Division by a zero speed gives the saturated time, which scales to zero.
module swept_aabb_pair_response #(
	parameter int COORD_FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// first_min_xy, first_max_xy, first_vel_xy, second_min_xy,
	// second_max_xy, second_vel_xy, common_layers
	input  logic [447:0] s_tdata,
	// req_type
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// first_vel_out_xy, second_vel_out_xy, first_sides, second_sides, hit_layers
	output logic [199:0] m_tdata,
	// hit
	output logic [0:0]   m_tuser
);
	import sapr_pkg::*;

	logic   fq_valid, fq_ready, bq_valid, bq_pop;
	front_t fq_item, bq_item;

	sapr_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_tvalid),
		.s_ready (s_tready),
		.s_data  (s_tdata),
		.s_user  (s_tuser),
		.q_valid (fq_valid),
		.q_ready (fq_ready),
		.q_item  (fq_item)
	);

	sapr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_item  (fq_item),
		.pop_valid  (bq_valid),
		.pop        (bq_pop),
		.pop_item   (bq_item)
	);

	sapr_back #(.FB(COORD_FRAC_BITS)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (bq_valid),
		.q_pop   (bq_pop),
		.q_item  (bq_item),
		.m_valid (m_tvalid),
		.m_ready (m_tready),
		.m_data  (m_tdata),
		.m_hit   (m_tuser[0])
	);
endmodule

[dv/swept_aabb_pair_response_tb.sv]
// Testbench for swept_aabb_pair_response: streams box pairs, predicts each response
// in a local model and checks results in order. Depends on sapr_pkg and the RTL.
`timescale 1ns / 100ps

module swept_aabb_pair_response_tb;
	import sapr_pkg::*;

	localparam int FRAC = 16;
	localparam longint TLIM = 64'sd2147483647;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [1:0]  kind;
		logic [63:0] a_min, a_max, a_vel, b_min, b_max, b_vel, layers;
	} pair_t;

	typedef struct packed {
		logic        hit;
		logic [63:0] a_vel, b_vel;
		logic [3:0]  a_sides, b_sides;
		logic [63:0] layers;
	} resp_t;

	logic         clk = 0;
	logic         arst_n = 0;
	logic         s_tvalid = 0;
	logic         s_tready;
	logic [447:0] s_tdata = '0;
	logic [1:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 0;
	logic [199:0] m_tdata;
	logic [0:0]   m_tuser;

	resp_t  pending_resp[$];
	int     errors = 0;
	int     sent = 0;
	int     checked = 0;
	int     hits = 0;
	longint cycles = 0;
	bit     sink_idle = 1;
	bit     hold_off = 0;
	bit     no_gaps = 0;

	swept_aabb_pair_response u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("swept_aabb_pair_response test failed");
			$finish;
		end
	end

	function automatic longint lo32(logic [63:0] w);
		return longint'($signed(w[31:0]));
	endfunction

	function automatic longint hi32(logic [63:0] w);
		return longint'($signed(w[63:32]));
	endfunction

	function automatic longint mag(longint a);
		return a < 0 ? -a : a;
	endfunction

	// contact time; inf flags a zero speed
	function automatic void contact_time(longint gap, longint speed,
			output bit inf, output longint t);
		longint q;
		inf = (speed == 0);
		t = 0;
		if (!inf) begin
			q = (mag(gap) <<< FRAC) / speed;
			if (q > TLIM)
				q = TLIM;
			t = gap < 0 ? -q : q;
		end
	endfunction

	function automatic bit time_lt(bit ai, longint av, bit bi, longint bv, bit use_mag);
		if (ai)
			return 0;
		if (bi)
			return 1;
		return use_mag ? mag(av) < mag(bv) : av < bv;
	endfunction

	function automatic logic [31:0] scale_vel(longint v, longint t);
		longint p, r;
		p = v * t;
		if (p < 0)
			r = -((-p + ((64'sd1 <<< FRAC) - 1)) >>> FRAC);
		else
			r = p >>> FRAC;
		if (r > 64'sd2147483647)
			r = 64'sd2147483647;
		if (r < -64'sd2147483648)
			r = -64'sd2147483648;
		return r[31:0];
	endfunction

	function automatic resp_t pair_response(pair_t p);
		resp_t  r;
		longint ax0, ay0, ax1, ay1, avx, avy, bx0, by0, bx1, by1, bvx, bvy;
		longint sbx, sby, spx, spy, gx, gy, tx, ty, k;
		bit     txi, tyi, x_first;
		ax0 = lo32(p.a_min); ay0 = hi32(p.a_min);
		ax1 = lo32(p.a_max); ay1 = hi32(p.a_max);
		avx = lo32(p.a_vel); avy = hi32(p.a_vel);
		bx0 = lo32(p.b_min); by0 = hi32(p.b_min);
		bx1 = lo32(p.b_max); by1 = hi32(p.b_max);
		bvx = lo32(p.b_vel); bvy = hi32(p.b_vel);
		sbx = p.kind == TYPE_MM ? bvx : 0;
		sby = p.kind == TYPE_MM ? bvy : 0;
		r = '0;
		r.a_vel = p.a_vel;
		r.b_vel = p.b_vel;
		r.hit = p.kind != TYPE_RSV && ax1 + avx > bx0 + sbx && ax0 + avx < bx1 + sbx
			&& ay1 + avy > by0 + sby && ay0 + avy < by1 + sby;
		if (!r.hit)
			return r;
		r.layers = p.layers;
		spx = mag(avx);
		spy = mag(avy);
		if (p.kind == TYPE_MM) begin
			spx += mag(bvx);
			spy += mag(bvy);
		end
		gx = (ax0 > bx0 ? ax0 : bx0) - (ax1 < bx1 ? ax1 : bx1);
		gy = (ay0 > by0 ? ay0 : by0) - (ay1 < by1 ? ay1 : by1);
		contact_time(gx, spx, txi, tx);
		contact_time(gy, spy, tyi, ty);
		if (time_lt(txi, tx, tyi, ty, 0)) begin
			r.a_sides = avx > 0 ? SIDE_RIGHT : SIDE_LEFT;
			r.b_sides = avx > 0 ? SIDE_LEFT : SIDE_RIGHT;
		end else begin
			r.a_sides = avy > 0 ? SIDE_DOWN : SIDE_UP;
			r.b_sides = avy > 0 ? SIDE_UP : SIDE_DOWN;
		end
		if (p.kind != TYPE_MA) begin
			x_first = time_lt(txi, tx, tyi, ty, 1);
			k = x_first ? (txi ? 0 : tx) : (tyi ? 0 : ty);
			if (x_first) begin
				r.a_vel[31:0] = scale_vel(avx, k);
				if (p.kind == TYPE_MM)
					r.b_vel[31:0] = scale_vel(bvx, k);
			end else begin
				r.a_vel[63:32] = scale_vel(avy, k);
				if (p.kind == TYPE_MM)
					r.b_vel[63:32] = scale_vel(bvy, k);
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		errors++;
		$display("mismatch at result %0d, %s: got %h, expected %h", checked, what, got, want);
	endtask

	// result checker
	always @(posedge clk) begin
		resp_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_resp.size() == 0) begin
				report_mismatch("unexpected transfer", m_tdata[63:0], 64'd0);
			end else begin
				want = pending_resp.pop_front();
				if (m_tuser[0] !== want.hit)
					report_mismatch("hit", 64'(m_tuser), 64'(want.hit));
				if (m_tdata[63:0] !== want.a_vel)
					report_mismatch("first_vel_out", m_tdata[63:0], want.a_vel);
				if (m_tdata[127:64] !== want.b_vel)
					report_mismatch("second_vel_out", m_tdata[127:64], want.b_vel);
				if (m_tdata[131:128] !== want.a_sides)
					report_mismatch("first_sides", 64'(m_tdata[131:128]), 64'(want.a_sides));
				if (m_tdata[135:132] !== want.b_sides)
					report_mismatch("second_sides", 64'(m_tdata[135:132]), 64'(want.b_sides));
				if (m_tdata[199:136] !== want.layers)
					report_mismatch("hit_layers", m_tdata[199:136], want.layers);
				hits += int'(want.hit);
			end
			checked++;
		end
	end

	// receiver stalls
	initial begin
		int n;
		forever begin
			@(negedge clk);
			if (hold_off) begin
				m_tready <= 0;
			end else if (sink_idle && !no_gaps && $urandom_range(0, 7) == 0) begin
				n = $urandom_range(1, 15);
				m_tready <= 0;
				repeat (n - 1) @(negedge clk);
			end else begin
				m_tready <= 1;
			end
		end
	end

	// valid stays high after a transfer until the next item or a gap replaces it
	task automatic send_pair(pair_t p);
		if (!no_gaps && $urandom_range(0, 9) == 0) begin
			s_tvalid <= 0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= p.kind;
		s_tdata <= {p.layers, p.b_vel, p.b_max, p.b_min, p.a_vel, p.a_max, p.a_min};
		do @(posedge clk); while (!s_tready);
		pending_resp.push_back(pair_response(p));
		sent++;
		@(negedge clk);
	endtask

	function automatic logic [63:0] xy(longint x, longint y);
		return {y[31:0], x[31:0]};
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// small coordinate, in units of 1/16, keeps boxes near each other
	function automatic longint near_coord(int span);
		return longint'($signed($urandom_range(0, 2 * span))) - span <<< 12;
	endfunction

	function automatic pair_t near_pair(logic [1:0] kind, int span);
		pair_t  p;
		longint x, y;
		p.kind = kind;
		x = near_coord(span); y = near_coord(span);
		p.a_min = xy(x, y);
		p.a_max = xy(x + near_coord(span) + (span << 12), y + near_coord(span) + (span << 12));
		x = near_coord(span); y = near_coord(span);
		p.b_min = xy(x, y);
		p.b_max = xy(x + near_coord(span) + (span << 12), y + near_coord(span) + (span << 12));
		p.a_vel = $urandom_range(0, 9) == 0 ? rand64() : xy(near_coord(span), near_coord(span));
		p.b_vel = $urandom_range(0, 4) == 0 ? 64'h0 : xy(near_coord(span), near_coord(span));
		if ($urandom_range(0, 5) == 0)
			p.a_vel[$urandom_range(0, 1) * 32 +: 32] = '0;
		p.layers = rand64();
		return p;
	endfunction

	task automatic test_directed();
		pair_t p;
		logic [1:0] k;
		for (int i = 0; i < 4; i++) begin
			k = i[1:0];
			// overlapping unit boxes, first moving right
			p = '{k, xy(0, 0), xy(32'sh10000, 32'sh10000), xy(32'sh8000, 0),
				xy(32'sh8000, 32'sh4000), xy(32'sh18000, 32'sh14000), xy(-32'sh4000, 0),
				64'hFFFF_FFFF_FFFF_FFFF};
			send_pair(p);
			// moving up with zero x speed
			p.a_vel = xy(0, -32'sh2000);
			p.b_vel = 64'h0;
			p.layers = 64'h0;
			send_pair(p);
		end
		// all zero velocities, overlapping boxes
		send_pair('{TYPE_MF, xy(0, 0), xy(100, 100), 64'h0, xy(50, 50), xy(150, 150), 64'h0, 64'h1});
		// extreme corners and velocities
		send_pair('{TYPE_MM, {2{32'h8000_0000}}, {2{32'h7FFF_FFFF}}, {2{32'h7FFF_FFFF}},
			{2{32'h8000_0000}}, {2{32'h7FFF_FFFF}}, {2{32'h8000_0000}}, 64'h8000_0000_0000_0001});
		send_pair('{TYPE_MF, {2{32'h8000_0000}}, {2{32'h7FFF_FFFF}}, {2{32'h0000_0001}},
			{2{32'hFFFF_FFFF}}, {2{32'h0000_0001}}, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF});
		// tiny speed on overlapping boxes: long contact time, below the saturated value
		send_pair('{TYPE_MF, xy(-32'sh4000_0000, 0), xy(32'sh4000_0000, 32'sh10000), xy(1, 1),
			xy(-32'sh100, 100), xy(32'sh100, 200), 64'h0, 64'h5});
		// inverted boxes
		send_pair('{TYPE_MM, xy(100, 100), xy(0, 0), xy(50, 50),
			xy(100, 100), xy(0, 0), xy(10, 10), 64'h2});
		// disjoint boxes
		send_pair('{TYPE_MF, xy(0, 0), xy(10, 10), xy(1, 1),
			xy(1000, 1000), xy(2000, 2000), 64'h0, 64'h3});
		for (int i = 0; i < 8; i++)
			send_pair('{2'(i % 3), rand64(), rand64(), rand64(), rand64(), rand64(), rand64(),
				rand64()});
	endtask

	task automatic test_random(int count);
		pair_t p;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 9) == 0)
				p = '{2'($urandom_range(0, 3)), rand64(), rand64(), rand64(), rand64(),
					rand64(), rand64(), rand64()};
			else
				p = near_pair($urandom_range(0, 19) == 0 ? TYPE_RSV : 2'($urandom_range(0, 2)),
					$urandom_range(0, 3) == 0 ? 32000 : 64);
			send_pair(p);
		end
	endtask

	task automatic test_backpressure();
		fork
			begin
				hold_off = 1;
				repeat (300) @(posedge clk);
				hold_off = 0;
			end
			test_random(60);
		join
	endtask

	task automatic test_streaming();
		no_gaps = 1;
		test_random(200);
	endtask

	initial begin
		int wait_cycles;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		test_directed();
		test_random(1000);
		test_backpressure();
		test_streaming();
		s_tvalid <= 0;
		wait_cycles = 0;
		while (pending_resp.size() != 0 && wait_cycles < 20000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (60) @(posedge clk);
		$display("%0d box pairs sent, %0d results checked, %0d hits", sent, checked, hits);
		$display("covered all pair kinds, reserved kind, extremes, stalls and full-rate streaming");
		if (errors == 0 && pending_resp.size() == 0) begin
			$display("swept_aabb_pair_response test passed");
		end else begin
			$display("%0d mismatches, %0d results missing", errors, pending_resp.size());
			$display("swept_aabb_pair_response test failed");
		end
		$finish;
	end
endmodule

[sim.f]
+incdir+sv
sv/sapr_pkg.sv
sv/sapr_front.sv
sv/sapr_queue.sv
sv/sapr_back.sv
sv/swept_aabb_pair_response.sv
dv/swept_aabb_pair_response_tb.sv
